// ----- hdl/lpg_pkg.sv -----
// Package for the LED pattern generator: operation, pattern and register codes,
// plus the item, configuration and status types. No dependencies.
package lpg_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_BURST = 2'd2;

  localparam logic [2:0] PAT_OFF   = 3'd0;
  localparam logic [2:0] PAT_ON    = 3'd1;
  localparam logic [2:0] PAT_SLOW  = 3'd2;
  localparam logic [2:0] PAT_FAST  = 3'd3;
  localparam logic [2:0] PAT_HEART = 3'd4;
  localparam logic [2:0] PAT_PULSE = 3'd5;

  localparam logic [2:0] HEART_LAST = 3'd4;

  localparam int unsigned ADDR_W = 5;

  localparam logic [2:0] REG_SLOW   = 3'd0;
  localparam logic [2:0] REG_FAST   = 3'd1;
  localparam logic [2:0] REG_BEAT   = 3'd2;
  localparam logic [2:0] REG_REST   = 3'd3;
  localparam logic [2:0] REG_PULSE  = 3'd4;
  localparam logic [2:0] REG_COUNT  = 3'd5;
  localparam logic [2:0] REG_PAUSE  = 3'd6;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] pattern_code;
    logic [7:0] blink_request;
  } lpg_item_t;

  typedef struct packed {
    logic [15:0] slow_half_period;
    logic [15:0] fast_half_period;
    logic [15:0] beat_time;
    logic [15:0] beat_rest_time;
    logic [15:0] pulse_half_period;
    logic [7:0]  default_pulse_count;
    logic [15:0] repeat_pause_time;
  } lpg_cfg_t;

  typedef struct packed {
    logic [2:0] pattern;
    logic [2:0] phase;
    logic       lamp;
  } lpg_status_t;

endpackage

// ----- hdl/lpg_regs.sv -----
// APB configuration registers of the LED pattern generator.
// Depends on lpg_pkg.
module lpg_regs import lpg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lpg_cfg_t          cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_half_period    <= 16'd500;
      cfg.fast_half_period    <= 16'd100;
      cfg.beat_time           <= 16'd80;
      cfg.beat_rest_time      <= 16'd600;
      cfg.pulse_half_period   <= 16'd150;
      cfg.default_pulse_count <= 8'd3;
      cfg.repeat_pause_time   <= 16'd400;
    end else if (wr_en) begin
      unique case (idx)
        REG_SLOW:  cfg.slow_half_period    <= pwdata[15:0];
        REG_FAST:  cfg.fast_half_period    <= pwdata[15:0];
        REG_BEAT:  cfg.beat_time           <= pwdata[15:0];
        REG_REST:  cfg.beat_rest_time      <= pwdata[15:0];
        REG_PULSE: cfg.pulse_half_period   <= pwdata[15:0];
        REG_COUNT: cfg.default_pulse_count <= pwdata[7:0];
        REG_PAUSE: cfg.repeat_pause_time   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SLOW:  prdata = {16'd0, cfg.slow_half_period};
      REG_FAST:  prdata = {16'd0, cfg.fast_half_period};
      REG_BEAT:  prdata = {16'd0, cfg.beat_time};
      REG_REST:  prdata = {16'd0, cfg.beat_rest_time};
      REG_PULSE: prdata = {16'd0, cfg.pulse_half_period};
      REG_COUNT: prdata = {24'd0, cfg.default_pulse_count};
      REG_PAUSE: prdata = {16'd0, cfg.repeat_pause_time};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

// ----- hdl/lpg_core.sv -----
// Pattern state and its one-step update for one tick or command.
// Depends on lpg_pkg.
module lpg_core import lpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  lpg_item_t   item,
  input  lpg_cfg_t    cfg,
  output logic        lamp_next,
  output lpg_status_t status
);

  logic [2:0]  current_pattern, current_pattern_next;
  logic [2:0]  saved_pattern, saved_pattern_next;
  logic        lamp_state;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic [2:0]  heartbeat_phase, heartbeat_phase_next;
  logic [8:0]  toggle_count, toggle_count_next;
  logic [7:0]  burst_target, burst_target_next;
  logic [15:0] pause_left, pause_left_next;

  logic [15:0] elapsed_inc;
  logic [15:0] beat_len;
  logic [7:0]  target;
  logic        slow_hit, fast_hit, beat_hit, pulse_hit;

  assign elapsed_inc = (elapsed_ticks == 16'hFFFF) ? elapsed_ticks : elapsed_ticks + 16'd1;
  assign beat_len    = (heartbeat_phase >= HEART_LAST) ? cfg.beat_rest_time : cfg.beat_time;
  assign target      = (burst_target != 8'd0) ? burst_target : cfg.default_pulse_count;
  assign slow_hit    = elapsed_inc >= cfg.slow_half_period;
  assign fast_hit    = elapsed_inc >= cfg.fast_half_period;
  assign beat_hit    = elapsed_inc >= beat_len;
  assign pulse_hit   = elapsed_inc >= cfg.pulse_half_period;

  always_comb begin
    current_pattern_next = current_pattern;
    saved_pattern_next   = saved_pattern;
    lamp_next            = lamp_state;
    elapsed_ticks_next   = elapsed_ticks;
    heartbeat_phase_next = heartbeat_phase;
    toggle_count_next    = toggle_count;
    burst_target_next    = burst_target;
    pause_left_next      = pause_left;
    unique case (item.operation)
      OP_TICK: begin
        elapsed_ticks_next = elapsed_inc;
        unique case (current_pattern)
          PAT_OFF: lamp_next = 1'b0;
          PAT_ON:  lamp_next = 1'b1;
          PAT_SLOW: begin
            if (slow_hit) begin
              elapsed_ticks_next = 16'd0;
              lamp_next          = ~lamp_state;
            end
          end
          PAT_FAST: begin
            if (fast_hit) begin
              elapsed_ticks_next = 16'd0;
              lamp_next          = ~lamp_state;
            end
          end
          PAT_HEART: begin
            if (beat_hit) begin
              elapsed_ticks_next   = 16'd0;
              lamp_next            = ~lamp_state;
              heartbeat_phase_next = (heartbeat_phase >= HEART_LAST) ? 3'd0
                                                                     : heartbeat_phase + 3'd1;
            end
          end
          PAT_PULSE: begin
            if (pause_left != 16'd0) begin
              pause_left_next = pause_left - 16'd1;
            end else if (toggle_count < {target, 1'b0}) begin
              if (pulse_hit) begin
                elapsed_ticks_next = 16'd0;
                lamp_next          = ~lamp_state;
                toggle_count_next  = toggle_count + 9'd1;
              end
            end else begin
              lamp_next = 1'b0;
              if (burst_target != 8'd0) begin
                burst_target_next    = 8'd0;
                current_pattern_next = saved_pattern;
              end else begin
                pause_left_next   = cfg.repeat_pause_time;
                toggle_count_next = 9'd0;
              end
            end
          end
          default: ;
        endcase
      end
      OP_SET: begin
        if (item.pattern_code <= PAT_PULSE && item.pattern_code != current_pattern) begin
          current_pattern_next = item.pattern_code;
          heartbeat_phase_next = 3'd0;
          toggle_count_next    = 9'd0;
          pause_left_next      = 16'd0;
        end
      end
      OP_BURST: begin
        saved_pattern_next   = current_pattern;
        burst_target_next    = item.blink_request;
        toggle_count_next    = 9'd0;
        current_pattern_next = PAT_PULSE;
        heartbeat_phase_next = 3'd0;
        pause_left_next      = 16'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_pattern <= PAT_OFF;
      saved_pattern   <= PAT_OFF;
      lamp_state      <= 1'b0;
      elapsed_ticks   <= 16'd0;
      heartbeat_phase <= 3'd0;
      toggle_count    <= 9'd0;
      burst_target    <= 8'd0;
      pause_left      <= 16'd0;
    end else if (step) begin
      current_pattern <= current_pattern_next;
      saved_pattern   <= saved_pattern_next;
      lamp_state      <= lamp_next;
      elapsed_ticks   <= elapsed_ticks_next;
      heartbeat_phase <= heartbeat_phase_next;
      toggle_count    <= toggle_count_next;
      burst_target    <= burst_target_next;
      pause_left      <= pause_left_next;
    end
  end

  assign status.pattern = current_pattern;
  assign status.phase   = heartbeat_phase;
  assign status.lamp    = lamp_state;

endmodule

// ----- hdl/led_pattern_generator.sv -----
// Top level of the LED pattern generator: input beat register, pattern core,
// result register and APB registers. Depends on lpg_pkg, lpg_regs, lpg_core.
// Each input beat is a 1 ms tick (tuser = 0), a set-pattern command (1) or a
// blink-burst request (2), and yields exactly one result beat with the LED
// state and the active-low pin level. Throughput is one beat per clock while the
// output is not stalled. The input register loads at the accepting edge; the
// combinational state update then fills the result register and raises result
// valid. Registers sit at byte addresses 0x00..0x18 and should be written only
// while idle.
module led_pattern_generator import lpg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,  // [2:0] pattern_code, [10:3] blink_request
  input  logic [1:0]        s_axis_tuser,  // [1:0] operation
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // [0] led_on, [1] pin_level
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  lpg_cfg_t    cfg;
  lpg_status_t status;
  lpg_item_t   in_item;
  logic        in_valid;
  logic        out_valid;
  logic        out_led;
  logic        lamp_next;
  logic        advance;
  logic        s_beat;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_beat) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      in_item.operation     <= s_axis_tuser;
      in_item.pattern_code  <= s_axis_tdata[2:0];
      in_item.blink_request <= s_axis_tdata[10:3];
    end
  end

  lpg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (in_item),
    .cfg       (cfg),
    .lamp_next (lamp_next),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_led <= lamp_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, ~out_led, out_led};

  a_pin_inverse: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1] != m_axis_tdata[0]))
    else $error("pin level not inverse of led state");

  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    (advance && in_item.operation == OP_TICK && status.pattern == PAT_OFF)
    |=> (m_axis_tdata[0] == 1'b0 && status.lamp == 1'b0))
    else $error("tick in off pattern left lamp lit");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    status.phase <= HEART_LAST)
    else $error("heartbeat phase out of range");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (m_axis_tdata[0] == status.lamp))
    else $error("result beat differs from lamp state");

endmodule

// ----- test/tb_led_pattern_generator.sv -----
// Self-checking testbench for led_pattern_generator: streams tick and command beats,
// predicts the LED state of each beat and compares every result beat in order.
// Depends on lpg_pkg and the led_pattern_generator RTL.
module tb_led_pattern_generator import lpg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         SETTLE      = 8;

  typedef struct packed {
    logic led_on;
    logic pin_level;
  } led_result_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;   // [2:0] pattern_code, [10:3] blink_request
  logic [1:0]        s_axis_tuser = '0;   // [1:0] operation
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // [0] led_on, [1] pin_level
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  led_pattern_generator u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicted block state
  lpg_cfg_t    led_cfg = '{16'd500, 16'd100, 16'd80, 16'd600, 16'd150, 8'd3, 16'd400};
  logic [2:0]  cur_pat = PAT_OFF;
  logic [2:0]  saved_pat = PAT_OFF;
  logic        lamp = 1'b0;
  logic [15:0] elapsed = '0;
  logic [2:0]  hb_phase = '0;
  logic [8:0]  toggles = '0;
  logic [7:0]  burst_tgt = '0;
  logic [15:0] pause_left = '0;

  lpg_item_t   cmd_backlog[$];
  led_result_t lamp_due[$];
  lpg_item_t   next_beat;
  led_result_t due;
  bit          calm = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  function automatic void toggle_at(logic [15:0] period);
    if (elapsed >= period) begin
      elapsed = '0;
      lamp = ~lamp;
    end
  endfunction

  function automatic void advance_tick();
    logic [15:0] len;
    logic [7:0]  target;
    if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
    case (cur_pat)
      PAT_OFF: lamp = 1'b0;
      PAT_ON: lamp = 1'b1;
      PAT_SLOW: toggle_at(led_cfg.slow_half_period);
      PAT_FAST: toggle_at(led_cfg.fast_half_period);
      PAT_HEART: begin
        len = (hb_phase >= HEART_LAST) ? led_cfg.beat_rest_time : led_cfg.beat_time;
        if (elapsed >= len) begin
          elapsed = '0;
          lamp = ~lamp;
          hb_phase = (hb_phase >= HEART_LAST) ? 3'd0 : hb_phase + 3'd1;
        end
      end
      PAT_PULSE: begin
        if (pause_left != 0) begin
          pause_left = pause_left - 16'd1;
        end else begin
          target = (burst_tgt != 0) ? burst_tgt : led_cfg.default_pulse_count;
          if (toggles < {target, 1'b0}) begin
            if (elapsed >= led_cfg.pulse_half_period) begin
              elapsed = '0;
              lamp = ~lamp;
              toggles = toggles + 9'd1;
            end
          end else begin
            lamp = 1'b0;
            if (burst_tgt != 0) begin
              burst_tgt = '0;
              cur_pat = saved_pat;
            end else begin
              pause_left = led_cfg.repeat_pause_time;
              toggles = '0;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic led_result_t predict_lamp(lpg_item_t it);
    case (it.operation)
      OP_TICK: advance_tick();
      OP_SET: begin
        if (it.pattern_code <= PAT_PULSE && it.pattern_code != cur_pat) begin
          cur_pat = it.pattern_code;
          hb_phase = '0;
          toggles = '0;
          pause_left = '0;
        end
      end
      OP_BURST: begin
        saved_pat = cur_pat;
        burst_tgt = it.blink_request;
        toggles = '0;
        cur_pat = PAT_PULSE;
        hb_phase = '0;
        pause_left = '0;
      end
      default: ;
    endcase
    return '{led_on: lamp, pin_level: ~lamp};
  endfunction

  function automatic lpg_item_t random_led_cmd();
    lpg_item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.operation = OP_TICK;
    it.pattern_code = 3'($urandom);
    it.blink_request = 8'($urandom);
    if (pick < 8) begin
      it.operation = OP_SET;
      if ($urandom_range(9) != 0) it.pattern_code = 3'($urandom_range(PAT_PULSE));
    end else if (pick < 14) begin
      it.operation = OP_BURST;
      if ($urandom_range(9) != 0) it.blink_request = 8'($urandom_range(4));
    end else if (pick < 16) begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
        next_beat = cmd_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, next_beat.blink_request, next_beat.pattern_code};
        s_axis_tuser <= next_beat.operation;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 14);
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lamp_due.size() == 0) begin
          $display("%0t: result beat with none expected, got led_on=%b pin_level=%b",
                   $time, m_axis_tdata[0], m_axis_tdata[1]);
          errors++;
        end else begin
          due = lamp_due.pop_front();
          if (m_axis_tdata[0] !== due.led_on) begin
            $display("%0t: led_on expected %b got %b", $time, due.led_on, m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[1] !== due.pin_level) begin
            $display("%0t: pin_level expected %b got %b", $time, due.pin_level,
                     m_axis_tdata[1]);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        lamp_due.push_back(predict_lamp('{s_axis_tuser, s_axis_tdata[2:0],
                                          s_axis_tdata[10:3]}));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SLOW: led_cfg.slow_half_period = val;
      REG_FAST: led_cfg.fast_half_period = val;
      REG_BEAT: led_cfg.beat_time = val;
      REG_REST: led_cfg.beat_rest_time = val;
      REG_PULSE: led_cfg.pulse_half_period = val;
      REG_COUNT: led_cfg.default_pulse_count = val[7:0];
      REG_PAUSE: led_cfg.repeat_pause_time = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [15:0] slow, fast, beat, rest, pulse, count, pause);
    write_reg(REG_SLOW, slow);
    write_reg(REG_FAST, fast);
    write_reg(REG_BEAT, beat);
    write_reg(REG_REST, rest);
    write_reg(REG_PULSE, pulse);
    write_reg(REG_COUNT, count);
    write_reg(REG_PAUSE, pause);
    @(negedge clk);
  endtask

  task automatic push_cmd(input logic [1:0] op, input logic [2:0] code,
                          input logic [7:0] req);
    cmd_backlog.push_back('{op, code, req});
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_cmd(OP_TICK, 3'($urandom), 8'($urandom));
  endtask

  task automatic push_random(input int n);
    repeat (n) cmd_backlog.push_back(random_led_cmd());
  endtask

  // all beats sent and all results back
  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || s_axis_tvalid || lamp_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);

    // reset defaults
    push_random(300);
    drain();

    // directed: every operation, ignored codes, burst returning to heartbeat
    set_all(16'd2, 16'd1, 16'd1, 16'd3, 16'd1, 16'd2, 16'd2);
    push_cmd(OP_TICK, 3'd0, 8'd0);
    push_cmd(OP_SET, PAT_ON, 8'd0);
    push_ticks(1);
    push_cmd(OP_SET, PAT_ON, 8'hFF);
    push_cmd(OP_SET, 3'd6, 8'd0);
    push_cmd(OP_SET, 3'd7, 8'd0);
    push_cmd(OP_UNUSED, 3'd7, 8'hFF);
    push_cmd(OP_SET, PAT_SLOW, 8'd0);
    push_ticks(2);
    push_cmd(OP_SET, PAT_FAST, 8'd0);
    push_ticks(1);
    push_cmd(OP_SET, PAT_HEART, 8'd0);
    push_ticks(3);
    push_cmd(OP_BURST, 3'd0, 8'd1);
    push_ticks(4);
    push_cmd(OP_SET, PAT_PULSE, 8'd0);
    push_ticks(2);
    push_cmd(OP_BURST, 3'd0, 8'd0);
    push_cmd(OP_BURST, 3'd0, 8'hFF);
    push_cmd(OP_SET, PAT_OFF, 8'd0);
    push_random(500);
    drain();

    // zero periods and an empty default burst
    set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_random(300);
    drain();

    // small periods, no idling on either side
    calm = 1'b1;
    set_all(16'd3, 16'd2, 16'd2, 16'd5, 16'd2, 16'd2, 16'd6);
    push_random(600);
    drain();
    calm = 1'b0;

    // largest settings
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'hFFFF);
    push_cmd(OP_SET, PAT_OFF, 8'd0);
    push_ticks(40);
    push_cmd(OP_SET, PAT_SLOW, 8'd0);
    push_ticks(2);
    push_cmd(OP_SET, PAT_HEART, 8'd0);
    push_ticks(2);
    push_cmd(OP_BURST, 3'd0, 8'hFF);
    push_ticks(5);
    drain();

    set_all(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
            16'($urandom_range(1, 9)), 16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
            16'($urandom_range(0, 12)));
    push_random(300);
    drain();

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
